### src/tjp_pkg.sv
// shared types, register codes and constants of the two-joint position controller
package tjp_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int JOINTS_DEF      = 2;
  localparam int MAX_LANES       = 2;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_POS_GAIN    = 3'd0;
  localparam reg_idx_t REG_POWER_CAP   = 3'd1;
  localparam reg_idx_t REG_SPEED_LIMIT = 3'd2;
  localparam reg_idx_t REG_SPEED_GAIN  = 3'd3;
  localparam reg_idx_t REG_ACCEL_LIMIT = 3'd4;
  localparam reg_idx_t REG_ACCEL_GAIN  = 3'd5;

  localparam logic [15:0] POS_GAIN_RST    = 16'd10;
  localparam logic [6:0]  POWER_CAP_RST   = 7'd50;
  localparam logic [15:0] SPEED_LIMIT_RST = 16'd2;
  localparam logic [15:0] SPEED_GAIN_RST  = 16'd54211;
  localparam logic [15:0] ACCEL_LIMIT_RST = 16'd0;
  localparam logic [15:0] ACCEL_GAIN_RST  = 16'd10842;

  typedef struct packed {
    logic [15:0] pos_gain;
    logic [6:0]  power_cap;
    logic [15:0] speed_limit;
    logic [15:0] speed_gain;
    logic [15:0] accel_limit;
    logic [15:0] accel_gain;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_DRIVE = 2'd0,
    MODE_OFF   = 2'd1,
    MODE_BRAKE = 2'd2
  } mode_t;

  // load enables of the back-end pipeline stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  localparam int          PCT_FRAC_BITS = 8;
  localparam logic [14:0] FULL_POWER    = 15'd25600;  // 100 percent in Q7.8
  localparam logic [7:0]  DUTY_MAX      = 8'd255;
  // floor(p * 255 / 25600) == (p * DUTY_MUL) >> DUTY_SHIFT for p up to full power
  localparam logic [20:0] DUTY_MUL      = 21'd1336935;
  localparam int          DUTY_SHIFT    = 27;

endpackage

### src/tjp_ifs.sv
// valid/ready channel interfaces for control steps and drive results
interface tjp_in_if #(
  parameter int COUNT_WIDTH = tjp_pkg::COUNT_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] target_a;
  logic signed [COUNT_WIDTH-1:0] target_b;
  logic signed [COUNT_WIDTH-1:0] position_a;
  logic signed [COUNT_WIDTH-1:0] position_b;
  logic                          open_stop_a;
  logic                          closed_stop_a;
  logic                          open_stop_b;
  logic                          closed_stop_b;
  logic                          sample_tick;

  modport source (
    output valid, target_a, target_b, position_a, position_b,
           open_stop_a, closed_stop_a, open_stop_b, closed_stop_b, sample_tick,
    input  ready
  );
  modport sink (
    input  valid, target_a, target_b, position_a, position_b,
           open_stop_a, closed_stop_a, open_stop_b, closed_stop_b, sample_tick,
    output ready
  );
endinterface

interface tjp_out_if;
  logic       valid;
  logic       ready;
  logic       forward_a;
  logic       forward_b;
  logic [7:0] duty_a;
  logic [7:0] duty_b;
  logic [1:0] mode_a;
  logic [1:0] mode_b;
  logic       speed_limited_a;
  logic       speed_limited_b;
  logic       accel_limited_a;
  logic       accel_limited_b;

  modport source (
    output valid, forward_a, forward_b, duty_a, duty_b, mode_a, mode_b,
           speed_limited_a, speed_limited_b, accel_limited_a, accel_limited_b,
    input  ready
  );
  modport sink (
    input  valid, forward_a, forward_b, duty_a, duty_b, mode_a, mode_b,
           speed_limited_a, speed_limited_b, accel_limited_a, accel_limited_b,
    output ready
  );
endinterface

### src/tjp_cfg_regs.sv
// apb-style configuration register bank
module tjp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tjp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tjp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tjp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                          pready,
  output tjp_pkg::cfg_t                 cfg
);
  import tjp_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_gain    <= POS_GAIN_RST;
      cfg_r.power_cap   <= POWER_CAP_RST;
      cfg_r.speed_limit <= SPEED_LIMIT_RST;
      cfg_r.speed_gain  <= SPEED_GAIN_RST;
      cfg_r.accel_limit <= ACCEL_LIMIT_RST;
      cfg_r.accel_gain  <= ACCEL_GAIN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_POS_GAIN:    cfg_r.pos_gain    <= pwdata[15:0];
        REG_POWER_CAP:   cfg_r.power_cap   <= pwdata[6:0];
        REG_SPEED_LIMIT: cfg_r.speed_limit <= pwdata[15:0];
        REG_SPEED_GAIN:  cfg_r.speed_gain  <= pwdata[15:0];
        REG_ACCEL_LIMIT: cfg_r.accel_limit <= pwdata[15:0];
        REG_ACCEL_GAIN:  cfg_r.accel_gain  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POS_GAIN:    prdata = CFG_DATA_W'(cfg_r.pos_gain);
      REG_POWER_CAP:   prdata = CFG_DATA_W'(cfg_r.power_cap);
      REG_SPEED_LIMIT: prdata = CFG_DATA_W'(cfg_r.speed_limit);
      REG_SPEED_GAIN:  prdata = CFG_DATA_W'(cfg_r.speed_gain);
      REG_ACCEL_LIMIT: prdata = CFG_DATA_W'(cfg_r.accel_limit);
      REG_ACCEL_GAIN:  prdata = CFG_DATA_W'(cfg_r.accel_gain);
      default:         prdata = '0;
    endcase
  end

endmodule

### src/tjp_joint_front.sv
// per-joint first stage: error, direction, speed/accel measurement and end-stop latch
module tjp_joint_front #(
  parameter int COUNT_WIDTH = tjp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic signed [COUNT_WIDTH-1:0] target,
  input  logic signed [COUNT_WIDTH-1:0] position,
  input  logic                          open_stop,
  input  logic                          closed_stop,
  input  logic                          tick,
  output logic [COUNT_WIDTH:0]          aerr,
  output logic                          fwd,
  output tjp_pkg::mode_t                mode,
  output logic [15:0]                   speed,
  output logic [15:0]                   accel
);
  import tjp_pkg::*;

  localparam int DW = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;

  logic signed [COUNT_WIDTH-1:0] last_pos_r;
  logic [15:0]                   speed_r;   // also serves as the previous speed
  logic [15:0]                   accel_r;
  logic                          latch_r;
  logic [COUNT_WIDTH:0]          aerr_r;
  logic                          fwd_r;
  mode_t                         mode_r;

  logic signed [COUNT_WIDTH:0] err;
  logic signed [COUNT_WIDTH:0] dpos;
  logic [COUNT_WIDTH:0]        adpos;
  logic [DW-1:0]               adpos_w;
  logic [15:0]                 sp;
  logic [15:0]                 ac;
  logic                        err_fwd;
  logic                        hit;
  mode_t                       mode_nxt;

  always_comb begin
    err     = {target[COUNT_WIDTH-1], target} - {position[COUNT_WIDTH-1], position};
    err_fwd = !err[COUNT_WIDTH];
    dpos    = {position[COUNT_WIDTH-1], position} - {last_pos_r[COUNT_WIDTH-1], last_pos_r};
    adpos   = dpos[COUNT_WIDTH] ? $unsigned(-dpos) : $unsigned(dpos);
    adpos_w = DW'(adpos);
    sp      = (adpos_w > DW'(17'h0FFFF)) ? 16'hFFFF : adpos_w[15:0];
    ac      = (sp >= speed_r) ? sp - speed_r : speed_r - sp;
    // end stops are active low and only count in the moving direction
    hit     = (!open_stop && err_fwd) || (!closed_stop && !err_fwd);
    if (!hit) begin
      mode_nxt = MODE_DRIVE;
    end else if (latch_r) begin
      mode_nxt = MODE_OFF;
    end else begin
      mode_nxt = MODE_BRAKE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      speed_r    <= '0;
      accel_r    <= '0;
      latch_r    <= 1'b0;
    end else if (en) begin
      latch_r <= hit;
      if (tick) begin
        last_pos_r <= position;
        speed_r    <= sp;
        accel_r    <= ac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aerr_r <= err_fwd ? $unsigned(err) : $unsigned(-err);
      fwd_r  <= err_fwd;
      mode_r <= mode_nxt;
    end
  end

  // the measurement state loads together with this stage, so it is the stage's value
  assign aerr  = aerr_r;
  assign fwd   = fwd_r;
  assign mode  = mode_r;
  assign speed = speed_r;
  assign accel = accel_r;

endmodule

### src/tjp_joint_power.sv
// per-joint back end: gain products, cap, rate penalties, clamp and duty scaling
module tjp_joint_power #(
  parameter int COUNT_WIDTH = tjp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  tjp_pkg::stage_en_t   en,
  input  tjp_pkg::cfg_t        cfg,
  input  logic [COUNT_WIDTH:0] aerr,
  input  logic                 fwd,
  input  tjp_pkg::mode_t       mode,
  input  logic [15:0]          speed,
  input  logic [15:0]          accel,
  output logic                 fwd_o,
  output logic [7:0]           duty_o,
  output tjp_pkg::mode_t       mode_o,
  output logic                 slim_o,
  output logic                 alim_o
);
  import tjp_pkg::*;

  localparam int PW = COUNT_WIDTH + 17;
  localparam int SW = 34;

  // stage 2
  logic [PW-1:0] p0_r;
  logic [31:0]   spen_r;
  logic [31:0]   apen_r;
  logic          fwd2_r, slim2_r, alim2_r;
  mode_t         mode2_r;
  // stage 3
  logic [14:0]   p0c_r;
  logic [32:0]   pen_r;
  logic          fwd3_r, slim3_r, alim3_r;
  mode_t         mode3_r;
  // stage 4
  logic [14:0]   pcl_r;
  logic          fwd4_r, slim4_r, alim4_r;
  mode_t         mode4_r;
  // result
  logic [7:0]    duty_r;
  logic          fwd5_r, slim5_r, alim5_r;
  mode_t         mode5_r;

  logic              slim, alim;
  logic [14:0]       capq;
  logic signed [SW-1:0] diff;
  logic [14:0]       pcl;
  logic [35:0]       prod;
  logic [7:0]        duty;

  assign slim = speed > cfg.speed_limit;
  assign alim = accel > cfg.accel_limit;
  assign capq = {cfg.power_cap, {PCT_FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      p0_r    <= PW'(cfg.pos_gain) * PW'(aerr);
      spen_r  <= slim ? 32'(cfg.speed_gain) * 32'(speed - cfg.speed_limit) : '0;
      apen_r  <= alim ? 32'(cfg.accel_gain) * 32'(accel - cfg.accel_limit) : '0;
      slim2_r <= slim;
      alim2_r <= alim;
      fwd2_r  <= fwd;
      mode2_r <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      p0c_r   <= (p0_r > PW'(capq)) ? capq : p0_r[14:0];
      pen_r   <= 33'(spen_r) + 33'(apen_r);
      slim3_r <= slim2_r;
      alim3_r <= alim2_r;
      fwd3_r  <= fwd2_r;
      mode3_r <= mode2_r;
    end
  end

  always_comb begin
    diff = $signed(SW'(p0c_r)) - $signed(SW'(pen_r));
    if (diff[SW-1]) begin
      pcl = '0;
    end else if (diff > $signed(SW'(FULL_POWER))) begin
      pcl = FULL_POWER;
    end else begin
      pcl = diff[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      pcl_r   <= pcl;
      slim4_r <= slim3_r;
      alim4_r <= alim3_r;
      fwd4_r  <= fwd3_r;
      mode4_r <= mode3_r;
    end
  end

  always_comb begin
    prod = 36'(pcl_r) * 36'(DUTY_MUL);
    unique case (mode4_r)
      MODE_BRAKE: duty = DUTY_MAX;
      MODE_OFF:   duty = '0;
      default:    duty = prod[DUTY_SHIFT +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      duty_r  <= duty;
      slim5_r <= slim4_r;
      alim5_r <= alim4_r;
      fwd5_r  <= fwd4_r;
      mode5_r <= mode4_r;
    end
  end

  assign fwd_o  = fwd5_r;
  assign duty_o = duty_r;
  assign mode_o = mode5_r;
  assign slim_o = slim5_r;
  assign alim_o = alim5_r;

endmodule

### src/two_joint_rate_limited_p_control_unit.sv
// two-joint proportional position controller with speed and acceleration limiting
// a control word passes through the input register, the front stage, the back-end stages and the result register
// throughput: one control word per cycle unless the output stalls; the joint measurement
//   state updates in one stage, so back-to-back words see each other's speed and accel without stalls
// reset (rst_n low, synchronous): registers to defaults, joint state and end-stop latches cleared
module two_joint_rate_limited_p_control_unit #(
  parameter int COUNT_WIDTH = tjp_pkg::COUNT_WIDTH_DEF,
  parameter int JOINTS      = tjp_pkg::JOINTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tjp_in_if.sink                         in_ch,
  tjp_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tjp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tjp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tjp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import tjp_pkg::*;

  localparam int LANES = (JOINTS < MAX_LANES) ? JOINTS : MAX_LANES;
  localparam int NST   = 6;  // input reg, four work stages, result reg

  cfg_t            cfg;
  logic [NST-1:0]  v_r;
  logic [NST-1:0]  v_nxt;
  logic [NST-1:0]  room;
  logic [NST-1:0]  load;
  stage_en_t       back_en;
  logic            tick_r;

  logic signed [COUNT_WIDTH-1:0] tgt_in   [LANES];
  logic signed [COUNT_WIDTH-1:0] pos_in   [LANES];
  logic                          open_in  [LANES];
  logic                          close_in [LANES];
  logic signed [COUNT_WIDTH-1:0] tgt_r    [LANES];
  logic signed [COUNT_WIDTH-1:0] pos_r    [LANES];
  logic                          open_r   [LANES];
  logic                          close_r  [LANES];

  logic [COUNT_WIDTH:0] aerr   [LANES];
  logic                 fwd    [LANES];
  mode_t                mode   [LANES];
  logic [15:0]          speed  [LANES];
  logic [15:0]          accel  [LANES];
  logic                 fwd_o  [LANES];
  logic [7:0]           duty_o [LANES];
  mode_t                mode_o [LANES];
  logic                 slim_o [LANES];
  logic                 alim_o [LANES];

  tjp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a stage has room when it is empty or its word moves on this cycle
  always_comb begin
    room[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      room[k] = !v_r[k] || room[k+1];
    end
    load[0]  = in_ch.valid && room[0];
    v_nxt[0] = room[0] ? in_ch.valid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      load[k]  = v_r[k-1] && room[k];
      v_nxt[k] = room[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign back_en.s2 = load[2];
  assign back_en.s3 = load[3];
  assign back_en.s4 = load[4];
  assign back_en.s5 = load[5];

  assign in_ch.ready  = room[0];
  assign out_ch.valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (load[0]) begin
      tick_r <= in_ch.sample_tick;
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    if (j == 0) begin : g_a
      assign tgt_in[j]   = in_ch.target_a;
      assign pos_in[j]   = in_ch.position_a;
      assign open_in[j]  = in_ch.open_stop_a;
      assign close_in[j] = in_ch.closed_stop_a;
    end else begin : g_b
      assign tgt_in[j]   = in_ch.target_b;
      assign pos_in[j]   = in_ch.position_b;
      assign open_in[j]  = in_ch.open_stop_b;
      assign close_in[j] = in_ch.closed_stop_b;
    end

    always_ff @(posedge clk) begin
      if (load[0]) begin
        tgt_r[j]   <= tgt_in[j];
        pos_r[j]   <= pos_in[j];
        open_r[j]  <= open_in[j];
        close_r[j] <= close_in[j];
      end
    end

    tjp_joint_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
      .clk         (clk),
      .rst_n       (rst_n),
      .en          (load[1]),
      .target      (tgt_r[j]),
      .position    (pos_r[j]),
      .open_stop   (open_r[j]),
      .closed_stop (close_r[j]),
      .tick        (tick_r),
      .aerr        (aerr[j]),
      .fwd         (fwd[j]),
      .mode        (mode[j]),
      .speed       (speed[j]),
      .accel       (accel[j])
    );

    tjp_joint_power #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_power (
      .clk    (clk),
      .en     (back_en),
      .cfg    (cfg),
      .aerr   (aerr[j]),
      .fwd    (fwd[j]),
      .mode   (mode[j]),
      .speed  (speed[j]),
      .accel  (accel[j]),
      .fwd_o  (fwd_o[j]),
      .duty_o (duty_o[j]),
      .mode_o (mode_o[j]),
      .slim_o (slim_o[j]),
      .alim_o (alim_o[j])
    );
  end

  assign out_ch.forward_a       = fwd_o[0];
  assign out_ch.duty_a          = duty_o[0];
  assign out_ch.mode_a          = mode_o[0];
  assign out_ch.speed_limited_a = slim_o[0];
  assign out_ch.accel_limited_a = alim_o[0];

  // a missing second joint reads as all zero
  if (LANES > 1) begin : g_out_b
    assign out_ch.forward_b       = fwd_o[1];
    assign out_ch.duty_b          = duty_o[1];
    assign out_ch.mode_b          = mode_o[1];
    assign out_ch.speed_limited_b = slim_o[1];
    assign out_ch.accel_limited_b = alim_o[1];
  end else begin : g_no_b
    assign out_ch.forward_b       = 1'b0;
    assign out_ch.duty_b          = '0;
    assign out_ch.mode_b          = MODE_DRIVE;
    assign out_ch.speed_limited_b = 1'b0;
    assign out_ch.accel_limited_b = 1'b0;
  end

endmodule

### tb/sv/tb_two_joint_rate_limited_p_control_unit.sv
// self-checking bench for the two-joint position controller: directed and random control steps vs in-bench model
module tb_two_joint_rate_limited_p_control_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tjp_pkg::*;

  localparam int CW           = 24;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 12;
  localparam int MAX_PRINTS   = 60;

  typedef struct packed {
    logic signed [CW-1:0] target_a;
    logic signed [CW-1:0] target_b;
    logic signed [CW-1:0] position_a;
    logic signed [CW-1:0] position_b;
    logic                 open_stop_a;
    logic                 closed_stop_a;
    logic                 open_stop_b;
    logic                 closed_stop_b;
    logic                 sample_tick;
  } step_t;

  // index 0 is joint a, index 1 joint b
  typedef struct packed {
    logic [1:0]      forward;
    logic [1:0][7:0] duty;
    logic [1:0][1:0] mode;
    logic [1:0]      speed_lim;
    logic [1:0]      accel_lim;
  } drive_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  tjp_in_if #(.COUNT_WIDTH(CW)) in_ch();
  tjp_out_if                    out_ch();

  two_joint_rate_limited_p_control_unit #(
    .COUNT_WIDTH(CW),
    .JOINTS(2)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  step_t  step_q[$];
  drive_t drive_expect_q[$];
  step_t  on_bus;
  drive_t seen;

  // controller model state
  cfg_t   cfg;
  longint last_pos[2];
  longint speed[2];
  longint prev_speed[2];
  longint accel[2];
  logic   latched[2];

  // random walk that keeps steps close to a plausible trajectory
  logic signed [CW-1:0] walk_pos[2];
  logic [3:0]           walk_stop;

  logic calm;
  int   mismatches;
  int   steps_sent;
  int   results_seen;
  int   hold_cycles;
  int   cycle_count;
  int   settings_used;
  int   brake_seen, off_seen, slim_seen, alim_seen;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic drive_t predict_drive(step_t s);
    drive_t r;
    longint tgt, pos, err, aerr, pwr, capq, d, sp, ac, dty;
    logic   hit_open, hit_closed, fwd;
    mode_t  m;
    r = '0;
    for (int j = 0; j < 2; j++) begin
      tgt        = (j == 0) ? longint'($signed(s.target_a)) : longint'($signed(s.target_b));
      pos        = (j == 0) ? longint'($signed(s.position_a)) : longint'($signed(s.position_b));
      hit_open   = (j == 0) ? !s.open_stop_a : !s.open_stop_b;
      hit_closed = (j == 0) ? !s.closed_stop_a : !s.closed_stop_b;
      err  = tgt - pos;
      fwd  = (err >= 0);
      aerr = fwd ? err : -err;
      // speed and accel use the position of this same step
      if (s.sample_tick) begin
        d  = pos - last_pos[j];
        if (d < 0) d = -d;
        sp = (d > 65535) ? 65535 : d;
        ac = sp - prev_speed[j];
        if (ac < 0) ac = -ac;
        last_pos[j]   = pos;
        speed[j]      = sp;
        accel[j]      = (ac > 65535) ? 65535 : ac;
        prev_speed[j] = sp;
      end
      pwr  = longint'(cfg.pos_gain) * aerr;
      capq = longint'(cfg.power_cap) * 256;
      if (pwr > capq) pwr = capq;
      if (speed[j] > longint'(cfg.speed_limit)) begin
        pwr -= longint'(cfg.speed_gain) * (speed[j] - longint'(cfg.speed_limit));
        r.speed_lim[j] = 1'b1;
        slim_seen++;
      end
      if (accel[j] > longint'(cfg.accel_limit)) begin
        pwr -= longint'(cfg.accel_gain) * (accel[j] - longint'(cfg.accel_limit));
        r.accel_lim[j] = 1'b1;
        alim_seen++;
      end
      if ((hit_open && fwd) || (hit_closed && !fwd)) begin
        if (!latched[j]) begin
          m = MODE_BRAKE;
          dty = longint'(DUTY_MAX);
          latched[j] = 1'b1;
          brake_seen++;
        end else begin
          m = MODE_OFF;
          dty = 0;
          off_seen++;
        end
      end else begin
        latched[j] = 1'b0;
        m = MODE_DRIVE;
        if (pwr > longint'(FULL_POWER)) pwr = longint'(FULL_POWER);
        else if (pwr < 0) pwr = 0;
        dty = (pwr * 255) / longint'(FULL_POWER);
      end
      r.forward[j] = fwd;
      r.duty[j]    = 8'(dty);
      r.mode[j]    = m;
    end
    return r;
  endfunction

  function automatic void check_drive(drive_t want, drive_t got);
    string jn;
    for (int j = 0; j < 2; j++) begin
      jn = (j == 0) ? "a" : "b";
      compare_field({"forward_", jn}, 32'(want.forward[j]), 32'(got.forward[j]));
      compare_field({"duty_", jn}, 32'(want.duty[j]), 32'(got.duty[j]));
      compare_field({"mode_", jn}, 32'(want.mode[j]), 32'(got.mode[j]));
      compare_field({"speed_limited_", jn}, 32'(want.speed_lim[j]),
                    32'(got.speed_lim[j]));
      compare_field({"accel_limited_", jn}, 32'(want.accel_lim[j]),
                    32'(got.accel_lim[j]));
    end
  endfunction

  function automatic logic [31:0] reg_value(reg_idx_t idx);
    case (idx)
      REG_POS_GAIN:    return {16'b0, cfg.pos_gain};
      REG_POWER_CAP:   return {25'b0, cfg.power_cap};
      REG_SPEED_LIMIT: return {16'b0, cfg.speed_limit};
      REG_SPEED_GAIN:  return {16'b0, cfg.speed_gain};
      REG_ACCEL_LIMIT: return {16'b0, cfg.accel_limit};
      REG_ACCEL_GAIN:  return {16'b0, cfg.accel_gain};
      default:         return '0;
    endcase
  endfunction

  function automatic step_t next_step();
    step_t                s;
    int                   d, r;
    logic signed [CW-1:0] tg[2];
    for (int j = 0; j < 2; j++) begin
      r = $urandom_range(99);
      if (r < 70) d = int'($urandom_range(16)) - 8;
      else if (r < 90) d = int'($urandom_range(600)) - 300;
      else d = 0;
      if (r >= 90) walk_pos[j] = CW'($urandom());
      else walk_pos[j] = walk_pos[j] + CW'(d);
      r = $urandom_range(99);
      if (r < 55) tg[j] = walk_pos[j] + CW'(int'($urandom_range(100)) - 50);
      else if (r < 85) tg[j] = walk_pos[j] + CW'(int'($urandom_range(10000)) - 5000);
      else tg[j] = CW'($urandom());
    end
    // stops stay released most of the time, hits come in short runs
    for (int k = 0; k < 4; k++)
      if (walk_stop[k] ? ($urandom_range(99) < 6) : ($urandom_range(99) < 30))
        walk_stop[k] = ~walk_stop[k];
    s.target_a      = tg[0];
    s.target_b      = tg[1];
    s.position_a    = walk_pos[0];
    s.position_b    = walk_pos[1];
    s.open_stop_a   = walk_stop[3];
    s.closed_stop_a = walk_stop[2];
    s.open_stop_b   = walk_stop[1];
    s.closed_stop_b = walk_stop[0];
    s.sample_tick   = ($urandom_range(3) == 0);
    return s;
  endfunction

  // stops: {open_a, closed_a, open_b, closed_b}, 0 means hit
  function automatic void push_step(logic signed [CW-1:0] ta, logic signed [CW-1:0] tb,
                                    logic signed [CW-1:0] pa, logic signed [CW-1:0] pb,
                                    logic [3:0] stops, logic tick);
    step_t s;
    s.target_a      = ta;
    s.target_b      = tb;
    s.position_a    = pa;
    s.position_b    = pb;
    s.open_stop_a   = stops[3];
    s.closed_stop_a = stops[2];
    s.open_stop_b   = stops[1];
    s.closed_stop_b = stops[0];
    s.sample_tick   = tick;
    step_q.push_back(s);
  endfunction

  task automatic cfg_read_check(reg_idx_t idx);
    logic [31:0] want;
    want = reg_value(idx);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    compare_field($sformatf("register %0d readback", idx), want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_POS_GAIN:    cfg.pos_gain    = value[15:0];
      REG_POWER_CAP:   cfg.power_cap   = value[6:0];
      REG_SPEED_LIMIT: cfg.speed_limit = value[15:0];
      REG_SPEED_GAIN:  cfg.speed_gain  = value[15:0];
      REG_ACCEL_LIMIT: cfg.accel_limit = value[15:0];
      REG_ACCEL_GAIN:  cfg.accel_gain  = value[15:0];
      default: ;
    endcase
    cfg_read_check(idx);
  endtask

  task automatic apply_setting(logic [31:0] pg, logic [31:0] cap, logic [31:0] sl,
                               logic [31:0] sg, logic [31:0] al, logic [31:0] ag);
    cfg_write(REG_POS_GAIN, pg);
    cfg_write(REG_POWER_CAP, cap);
    cfg_write(REG_SPEED_LIMIT, sl);
    cfg_write(REG_SPEED_GAIN, sg);
    cfg_write(REG_ACCEL_LIMIT, al);
    cfg_write(REG_ACCEL_GAIN, ag);
    settings_used++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (step_q.size() != 0 || in_ch.valid || drive_expect_q.size() != 0);
  endtask

  task automatic run_random(int n);
    @(negedge clk);
    repeat (n) step_q.push_back(next_step());
    wait_drained();
  endtask

  // driver: one control word per handshake, prediction at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        drive_expect_q.push_back(predict_drive(on_bus));
        steps_sent++;
      end
      if (step_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
        on_bus = step_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.target_a      <= on_bus.target_a;
        in_ch.target_b      <= on_bus.target_b;
        in_ch.position_a    <= on_bus.position_a;
        in_ch.position_b    <= on_bus.position_b;
        in_ch.open_stop_a   <= on_bus.open_stop_a;
        in_ch.closed_stop_a <= on_bus.closed_stop_a;
        in_ch.open_stop_b   <= on_bus.open_stop_b;
        in_ch.closed_stop_b <= on_bus.closed_stop_b;
        in_ch.sample_tick   <= on_bus.sample_tick;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: check each result word, with two long back-pressure windows
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.forward   = {out_ch.forward_b, out_ch.forward_a};
        seen.duty      = {out_ch.duty_b, out_ch.duty_a};
        seen.mode      = {out_ch.mode_b, out_ch.mode_a};
        seen.speed_lim = {out_ch.speed_limited_b, out_ch.speed_limited_a};
        seen.accel_lim = {out_ch.accel_limited_b, out_ch.accel_limited_a};
        if (drive_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_PRINTS)
            $display("%0t: result word with nothing expected, expected none, got %h",
                     $time, seen);
        end else begin
          check_drive(drive_expect_q.pop_front(), seen);
        end
        results_seen++;
        if (results_seen == 400 || results_seen == 1300) hold_cycles = 250;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid         = 1'b0;
    in_ch.target_a      = '0;
    in_ch.target_b      = '0;
    in_ch.position_a    = '0;
    in_ch.position_b    = '0;
    in_ch.open_stop_a   = 1'b1;
    in_ch.closed_stop_a = 1'b1;
    in_ch.open_stop_b   = 1'b1;
    in_ch.closed_stop_b = 1'b1;
    in_ch.sample_tick   = 1'b0;
    out_ch.ready        = 1'b0;
    calm          = 1'b0;
    mismatches    = 0;
    steps_sent    = 0;
    results_seen  = 0;
    hold_cycles   = 0;
    cycle_count   = 0;
    settings_used = 1;
    brake_seen    = 0;
    off_seen      = 0;
    slim_seen     = 0;
    alim_seen     = 0;
    walk_pos[0]   = '0;
    walk_pos[1]   = '0;
    walk_stop     = 4'b1111;
    cfg.pos_gain    = POS_GAIN_RST;
    cfg.power_cap   = POWER_CAP_RST;
    cfg.speed_limit = SPEED_LIMIT_RST;
    cfg.speed_gain  = SPEED_GAIN_RST;
    cfg.accel_limit = ACCEL_LIMIT_RST;
    cfg.accel_gain  = ACCEL_GAIN_RST;
    for (int j = 0; j < 2; j++) begin
      last_pos[j]   = 0;
      speed[j]      = 0;
      prev_speed[j] = 0;
      accel[j]      = 0;
      latched[j]    = 1'b0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 6; i++) cfg_read_check(reg_idx_t'(i));

    // directed steps under reset settings
    @(negedge clk);
    push_step(0, 0, 0, 0, 4'b1111, 1'b0);
    push_step(24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff, 4'b1111, 1'b0);
    push_step(3, -3, 0, 0, 4'b1111, 1'b1);
    push_step(5, 5, 24'sh7fffff, 24'sh800000, 4'b1111, 1'b1);
    push_step(5, 5, 24'sh7fffff, 24'sh800000, 4'b1111, 1'b1);
    push_step(5, 5, 24'sh7fffff, 24'sh800000, 4'b1111, 1'b0);
    push_step(10, -10, 10, -10, 4'b1111, 1'b1);
    push_step(12, -12, 11, -9, 4'b1111, 1'b1);
    push_step(50, -50, 0, 0, 4'b0111, 1'b0);
    push_step(50, -50, 0, 0, 4'b0111, 1'b0);
    push_step(50, -50, 0, 0, 4'b0110, 1'b0);
    push_step(50, -50, 0, 0, 4'b0110, 1'b0);
    push_step(50, -50, 0, 0, 4'b1111, 1'b0);
    push_step(50, 50, 0, 0, 4'b1011, 1'b0);
    push_step(-50, -50, 0, 0, 4'b1110, 1'b0);
    push_step(0, 0, 0, 0, 4'b0101, 1'b0);
    push_step(0, 0, 0, 0, 4'b0101, 1'b0);
    push_step(-1, -1, 0, 0, 4'b0101, 1'b0);
    push_step(0, 0, 0, 0, 4'b0101, 1'b1);
    push_step(-8388608, 8388607, 8388607, -8388608, 4'b0000, 1'b1);
    run_random(300);

    // all registers at zero
    apply_setting(0, 0, 0, 0, 0, 0);
    run_random(330);

    // all registers at full scale, power cap above one hundred percent
    apply_setting(32'hffff, 32'h7f, 32'hffff, 32'hffff, 32'hffff, 32'hffff);
    run_random(330);

    // moderate gains, no random idling on either side
    apply_setting(256, 100, 20, 512, 5, 256);
    @(negedge clk);
    calm = 1'b1;
    run_random(330);
    calm = 1'b0;

    apply_setting($urandom(), $urandom(), $urandom_range(400), $urandom(),
                  $urandom_range(200), $urandom());
    run_random(330);

    apply_setting($urandom_range(4096), $urandom_range(127), $urandom_range(50),
                  $urandom_range(2048), $urandom_range(20), $urandom_range(2048));
    run_random(330);

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d control steps over %0d register settings, %0d result words",
             steps_sent, settings_used, results_seen);
    $display("joint outcomes: %0d brake pulses, %0d off at stop, %0d speed limited,",
             brake_seen, off_seen, slim_seen, " %0d accel limited", alim_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
